// File: rtl/core/spims_pkg.sv
// spims_pkg: shared types, codes and constants of the spi master byte shifter
// no dependencies; imported by the engine, the output buffer and the top level
`default_nettype none

package spims_pkg;

    // register indexes of the configuration port
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 4;

    localparam logic [CfgIndexWidth-1:0] CFG_CLOCK_MODE     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_LSB_LEAD       = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_DIVIDER_SELECT = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_SLAVE_COUNT    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_ENABLE         = 3'd4;

    // command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_READ     = 3'd2;
    localparam logic [2:0] CMD_SELECT   = 3'd3;
    localparam logic [2:0] CMD_DESELECT = 3'd4;

    // slave select lines: the port is eight wide, usable lines capped by MaxSlaves
    localparam int SelectWidth = 8;
    localparam int MaxSlaves   = 8;
    localparam logic [3:0] LineCap =
        4'((MaxSlaves < SelectWidth) ? MaxSlaves : SelectWidth);

    localparam logic [3:0] LastEdge = 4'd15;

    typedef struct packed {
        logic [1:0] clock_mode;
        logic       lsb_lead;
        logic [2:0] divider_select;
        logic [3:0] slave_count;
        logic       enable;
    } cfg_t;

    typedef struct packed {
        logic                   sclk;
        logic                   mosi;
        logic [SelectWidth-1:0] slave_select_n;
        logic                   busy_res;
        logic                   transfer_done;
        logic [7:0]             rx_data;
        logic                   accepted;
    } result_t;

    // half of the serial clock period in system ticks
    function automatic logic [6:0] half_period(input logic [2:0] sel);
        logic [6:0] half;
        unique case (sel)
            3'd0:    half = 7'd2;
            3'd1:    half = 7'd8;
            3'd2:    half = 7'd32;
            3'd3:    half = 7'd64;
            3'd4:    half = 7'd1;
            3'd5:    half = 7'd4;
            3'd6:    half = 7'd16;
            default: half = 7'd32;
        endcase
        return half;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/spims_engine.sv
// spims_engine: transfer state and per-tick update of the spi master
// depends on spims_pkg
`default_nettype none

module spims_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tick_en,
    input  wire spims_pkg::cfg_t    cfg,
    input  wire logic [2:0]         command,
    input  wire logic [7:0]         tx_data,
    input  wire logic [7:0]         slave_index,
    input  wire logic               miso,
    output spims_pkg::result_t      result
);
    import spims_pkg::*;

    logic [7:0]             shift_reg, shift_next;
    logic [3:0]             bit_cnt_reg, bit_cnt_next;
    logic [6:0]             div_cnt_reg, div_cnt_next;
    logic                   clk_level_reg, clk_level_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [7:0]             rx_byte_reg, rx_byte_next;
    logic [SelectWidth-1:0] select_reg, select_next;

    always_comb
    begin
        logic                   cpol;
        logic                   cpha;
        logic [7:0]             div_inc;
        logic                   sample;
        logic [3:0]             line_count;
        logic [SelectWidth-1:0] line_mask;

        cpol = cfg.clock_mode[1];
        cpha = cfg.clock_mode[0];

        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        clk_level_next = clk_level_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        rx_byte_next   = rx_byte_reg;
        select_next    = select_reg;
        result         = '0;

        // abort on disable
        if (busy_reg && !cfg.enable)
        begin
            busy_next    = 1'b0;
            bit_cnt_next = '0;
            div_cnt_next = '0;
        end

        // advance a running transfer
        div_inc = {1'b0, div_cnt_reg} + 8'd1;
        sample  = ~bit_cnt_reg[0] ^ cpha;
        if (busy_next)
        begin
            if (div_inc < {1'b0, half_period(cfg.divider_select)})
            begin
                div_cnt_next = div_inc[6:0];
            end
            else
            begin
                div_cnt_next   = '0;
                clk_level_next = ~clk_level_reg;
                if (sample)
                begin
                    rx_byte_next = cfg.lsb_lead ? {miso, rx_byte_reg[7:1]}
                                                : {rx_byte_reg[6:0], miso};
                end
                else if (!(cpha && bit_cnt_reg == '0))
                begin
                    shift_next = cfg.lsb_lead ? {1'b0, shift_reg[7:1]}
                                              : {shift_reg[6:0], 1'b0};
                end
                if (bit_cnt_reg == LastEdge)
                begin
                    bit_cnt_next   = '0;
                    busy_next      = 1'b0;
                    done_next      = 1'b1;
                    clk_level_next = cpol;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                end
            end
        end
        if (!busy_next)
        begin
            clk_level_next = cpol;
        end

        // command
        line_count = (cfg.slave_count < LineCap) ? cfg.slave_count : LineCap;
        line_mask  = SelectWidth'(1) << slave_index[2:0];
        unique case (command) inside
            CMD_TICK:
            begin
                result.accepted = 1'b1;
            end
            CMD_START:
            begin
                if (!busy_next && cfg.enable)
                begin
                    shift_next      = tx_data;
                    bit_cnt_next    = '0;
                    div_cnt_next    = '0;
                    clk_level_next  = cpol;
                    busy_next       = 1'b1;
                    result.accepted = 1'b1;
                end
            end
            CMD_READ:
            begin
                // the byte may have been completed on this very tick
                if (!busy_next)
                begin
                    result.rx_data  = rx_byte_next;
                    done_next       = 1'b0;
                    result.accepted = 1'b1;
                end
            end
            CMD_SELECT, CMD_DESELECT:
            begin
                if (slave_index < {4'd0, line_count})
                begin
                    select_next = (command == CMD_SELECT) ? (select_reg & ~line_mask)
                                                          : (select_reg | line_mask);
                    result.accepted = 1'b1;
                end
            end
            default:
            begin
                result.accepted = 1'b0;
            end
        endcase

        result.sclk           = busy_next ? clk_level_next : cpol;
        result.mosi           = busy_next & (cfg.lsb_lead ? shift_next[0] : shift_next[7]);
        result.slave_select_n = select_next;
        result.busy_res       = busy_next;
        result.transfer_done  = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bit_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            clk_level_reg <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            rx_byte_reg   <= '0;
            select_reg    <= '1;
        end
        else if (tick_en)
        begin
            shift_reg     <= shift_next;
            bit_cnt_reg   <= bit_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            clk_level_reg <= clk_level_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            rx_byte_reg   <= rx_byte_next;
            select_reg    <= select_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/spims_out_buf.sv
// spims_out_buf: output register with one skid entry for result transfers
// depends on spims_pkg
`default_nettype none

module spims_out_buf
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire spims_pkg::result_t  push_data,
    output logic                     full,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output spims_pkg::result_t       out_data
);
    import spims_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/spi_master_byte_shifter.sv
// spi_master_byte_shifter: top level of the spi master, config registers and wiring
// depends on spims_pkg, spims_engine, spims_out_buf
//
// usage
//   each input transfer is one tick of the peripheral: a command (tick, start,
//   read, select, deselect) with tx_data, slave_index and the miso level seen
//   on that tick. each accepted tick yields exactly one result transfer with
//   sclk, mosi, slave_select_n, busy_res, transfer_done, rx_data, accepted.
//   the input side takes a tick at a clock edge with in_valid high and in_stall
//   low; the result side hands one over with out_valid high and out_stall low.
//   the tick updates the shifter state and its result lands in the output register
//   at the same edge if that register is free. throughput, with in_stall low, is one tick
//   per cycle, set by the single-pass update between state and output registers.
//   when the receiver stalls, one more result is caught in a skid entry; only
//   with that entry in use does in_stall go high, and it drops once the
//   receiver takes the waiting result.
//   config writes use cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high and indexes beyond the register list are ignored.
//   reset: mode 0, msb first, divide by 4, eight slaves, disabled, all select
//   lines high, flags and bytes cleared, no result pending.
`default_nettype none

module spi_master_byte_shifter
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    // config write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [spims_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  wire logic [spims_pkg::CfgDataWidth-1:0]     cfg_data,

    // tick input channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [2:0]                             command,
    input  wire logic [7:0]                             tx_data,
    input  wire logic [7:0]                             slave_index,
    input  wire logic                                   miso,

    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        sclk,
    output logic                                        mosi,
    output logic [spims_pkg::SelectWidth-1:0]           slave_select_n,
    output logic                                        busy_res,
    output logic                                        transfer_done,
    output logic [7:0]                                  rx_data,
    output logic                                        accepted
);
    import spims_pkg::*;

    cfg_t    cfg_reg;
    logic    in_xfer;
    logic    buf_full;
    result_t tick_result;
    result_t out_result;

    assign cfg_ready = 1'b1;

    // config registers, written straight from the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_mode     <= 2'd0;
            cfg_reg.lsb_lead       <= 1'b0;
            cfg_reg.divider_select <= 3'd0;
            cfg_reg.slave_count    <= 4'd8;
            cfg_reg.enable         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CLOCK_MODE:     cfg_reg.clock_mode     <= cfg_data[1:0];
                CFG_LSB_LEAD:       cfg_reg.lsb_lead       <= cfg_data[0];
                CFG_DIVIDER_SELECT: cfg_reg.divider_select <= cfg_data[2:0];
                CFG_SLAVE_COUNT:    cfg_reg.slave_count    <= cfg_data;
                CFG_ENABLE:         cfg_reg.enable         <= cfg_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // a tick is taken whenever the skid entry is free
    assign in_stall = buf_full;
    assign in_xfer  = in_valid && !in_stall;

    spims_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (in_xfer),
        .cfg         (cfg_reg),
        .command     (command),
        .tx_data     (tx_data),
        .slave_index (slave_index),
        .miso        (miso),
        .result      (tick_result)
    );

    spims_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (tick_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign sclk           = out_result.sclk;
    assign mosi           = out_result.mosi;
    assign slave_select_n = out_result.slave_select_n;
    assign busy_res       = out_result.busy_res;
    assign transfer_done  = out_result.transfer_done;
    assign rx_data        = out_result.rx_data;
    assign accepted       = out_result.accepted;

endmodule

`default_nettype wire

// File: rtl/core/spims_checker.sv
// spims_checker: port-level assertions for the spi master, bound to the top level
// depends on spi_master_byte_shifter ports only
`default_nettype none

module spims_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       mosi,
    input wire logic       busy_res,
    input wire logic [7:0] rx_data,
    input wire logic       accepted
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // mosi is low whenever no transfer runs
    a_mosi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !mosi)
        else $error("mosi high while idle");

    // a rejected command returns no byte
    a_rx_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> rx_data == 8'd0)
        else $error("rx byte on rejected command");

endmodule

bind spi_master_byte_shifter spims_checker u_spims_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mosi      (mosi),
    .busy_res  (busy_res),
    .rx_data   (rx_data),
    .accepted  (accepted)
);

`default_nettype wire
